// ===== src/chmlp_pkg.sv =====
// Shared widths and hashing constants for the cell hash map.
package chmlp_pkg;

	localparam int SLOT_COUNT_DEFAULT = 256;

	localparam int ROW_W    = 20;
	localparam int COL_W    = 14;
	localparam int KEY_W    = ROW_W + COL_W;
	localparam int HANDLE_W = 32;
	localparam int LENGTH_W = 16;
	localparam int VALUE_W  = HANDLE_W + LENGTH_W;
	localparam int HEIGHT_W = ROW_W + 1;
	localparam int WIDTH_W  = COL_W + 1;

	localparam int IN_DATA_W  = 88;
	localparam int OUT_DATA_W = 48;

	// Golden-ratio multiplier, split into 32-bit halves.
	localparam logic [31:0] HASH_MULT_HI = 32'h9E37_79B9;
	localparam logic [31:0] HASH_MULT_LO = 32'h7F4A_7C15;

	localparam logic CMD_LOOKUP = 1'b0;
	localparam logic CMD_SET    = 1'b1;

endpackage

// ===== src/cell_hash_map_linear_probe_core.sv =====
// Cell hash map: open-addressing index table with linear probing over a dense entry store.
// An out-of-bounds lookup goes straight to output load; others pass HASH0, HASH1, HASH2,
// slot read, slot check and output load if the probe ends at an empty slot, plus an entry
// check on a hit and a slot read, slot check and entry check per occupied slot passed.
// Sequential; the load waits while m_axis is stalled, then the next word is taken in idle.
// Reset: control clears at once, then the clear state empties every slot, tready low.
module cell_hash_map_linear_probe_core #(
	parameter int SLOT_COUNT = chmlp_pkg::SLOT_COUNT_DEFAULT
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             s_axis_tvalid,
	output logic                             s_axis_tready,
	// row, col, text_handle, text_length, zero fill (lowest bit first)
	input  logic [chmlp_pkg::IN_DATA_W-1:0]  s_axis_tdata,
	// command
	input  logic                             s_axis_tuser,
	output logic                             m_axis_tvalid,
	input  logic                             m_axis_tready,
	// handle_out, length_out (lowest bit first)
	output logic [chmlp_pkg::OUT_DATA_W-1:0] m_axis_tdata,
	// found, status (lowest bit first)
	output logic [1:0]                       m_axis_tuser
);

	localparam int SW    = $clog2(SLOT_COUNT);
	localparam int SCW   = $clog2(SLOT_COUNT + 1);
	localparam int EMAX  = SLOT_COUNT / 2;
	localparam int EW    = $clog2(EMAX);
	localparam int CNTW  = $clog2(EMAX + 1);
	localparam int KEY_W = chmlp_pkg::KEY_W;
	localparam int VAL_W = chmlp_pkg::VALUE_W;
	localparam int ENT_W = KEY_W + VAL_W;
	localparam int HW    = chmlp_pkg::HANDLE_W;
	localparam int LW    = chmlp_pkg::LENGTH_W;

	typedef enum logic [8:0] {
		ST_CLEAR    = 9'b0_0000_0001,
		ST_IDLE     = 9'b0_0000_0010,
		ST_HASH0    = 9'b0_0000_0100,
		ST_HASH1    = 9'b0_0000_1000,
		ST_HASH2    = 9'b0_0001_0000,
		ST_SLOT_RD  = 9'b0_0010_0000,
		ST_SLOT_CHK = 9'b0_0100_0000,
		ST_ENT_CHK  = 9'b0_1000_0000,
		ST_DONE     = 9'b1_0000_0000
	} state_t;

	state_t state_q;

	// Slot memory holds {valid, entry number}; entry memory holds {key, length, handle}.
	logic [EW:0]      slot_mem [SLOT_COUNT];
	logic [ENT_W-1:0] ent_mem  [EMAX];
	logic [EW:0]      slot_rd_q;
	logic [ENT_W-1:0] ent_rd_q;

	logic                        cmd_q;
	logic [KEY_W-1:0]            key_q;
	logic [HW-1:0]               handle_q;
	logic [LW-1:0]               length_q;
	logic [31:0]                 prod_q;
	logic [31:0]                 hash_q;
	logic [SW-1:0]               probe_q;
	logic [SW-1:0]               steps_q;
	logic [CNTW-1:0]             count_q;
	logic [chmlp_pkg::HEIGHT_W-1:0] height_q;
	logic [chmlp_pkg::WIDTH_W-1:0]  width_q;
	logic                        res_found_q;
	logic [HW-1:0]               res_handle_q;
	logic [LW-1:0]               res_length_q;
	logic                        res_status_q;
	logic                        out_valid_q;
	logic [chmlp_pkg::OUT_DATA_W-1:0] out_data_q;
	logic [1:0]                  out_user_q;

	logic                        in_cmd;
	logic [chmlp_pkg::ROW_W-1:0] in_row;
	logic [chmlp_pkg::COL_W-1:0] in_col;
	logic [chmlp_pkg::HEIGHT_W-1:0] row_next;
	logic [chmlp_pkg::WIDTH_W-1:0]  col_next;
	logic                        out_of_bounds;

	logic [63:0]       mul_lo;
	logic [31:0]       mul_cross;
	logic [31:0]       mul_top;
	logic [31:0]       hash_hi;
	logic [32+SCW-1:0] home_prod;
	logic [SW-1:0]     probe_next;

	logic             slot_vld;
	logic [EW-1:0]    slot_idx;
	logic             key_hit;
	logic             has_room;

	logic             slot_we;
	logic [EW:0]      slot_wd;
	logic             ent_we;
	logic [EW-1:0]    ent_wa;
	logic [ENT_W-1:0] ent_wd;

	assign in_cmd   = s_axis_tuser;
	assign in_row   = s_axis_tdata[chmlp_pkg::ROW_W-1:0];
	assign in_col   = s_axis_tdata[KEY_W-1:chmlp_pkg::ROW_W];
	assign row_next = chmlp_pkg::HEIGHT_W'(in_row) + 1'b1;
	assign col_next = chmlp_pkg::WIDTH_W'(in_col) + 1'b1;
	assign out_of_bounds = (chmlp_pkg::HEIGHT_W'(in_row) >= height_q) ||
		(chmlp_pkg::WIDTH_W'(in_col) >= width_q);

	// m = key * multiplier mod 2^64 in three partial products; only its top half is kept.
	assign mul_lo    = {32'd0, key_q[31:0]} * {32'd0, chmlp_pkg::HASH_MULT_LO};
	assign mul_cross = key_q[31:0] * chmlp_pkg::HASH_MULT_HI;
	assign mul_top   = {30'd0, key_q[KEY_W-1:32]} * chmlp_pkg::HASH_MULT_LO;
	assign hash_hi   = prod_q + mul_cross + mul_top;
	assign home_prod = {SCW'(0), hash_q} * {32'd0, SCW'(SLOT_COUNT)};
	assign probe_next = (probe_q == SW'(SLOT_COUNT - 1)) ? '0 : probe_q + 1'b1;

	assign slot_vld = slot_rd_q[EW];
	assign slot_idx = slot_rd_q[EW-1:0];
	assign key_hit  = (ent_rd_q[ENT_W-1:VAL_W] == key_q);
	assign has_room = (count_q < CNTW'(EMAX));

	always_comb begin
		slot_we = 1'b0;
		slot_wd = '0;
		ent_we  = 1'b0;
		ent_wa  = slot_idx;
		ent_wd  = {key_q, length_q, handle_q};
		unique case (state_q)
			ST_CLEAR: begin
				slot_we = 1'b1;
			end
			ST_SLOT_CHK: begin
				if (!slot_vld && cmd_q == chmlp_pkg::CMD_SET && has_room) begin
					slot_we = 1'b1;
					slot_wd = {1'b1, count_q[EW-1:0]};
					ent_we  = 1'b1;
					ent_wa  = count_q[EW-1:0];
				end
			end
			ST_ENT_CHK: begin
				if (slot_vld && key_hit && cmd_q == chmlp_pkg::CMD_SET) begin
					ent_we = 1'b1;
				end
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (slot_we) begin
			slot_mem[probe_q] <= slot_wd;
		end
		if (ent_we) begin
			ent_mem[ent_wa] <= ent_wd;
		end
		slot_rd_q <= slot_mem[probe_q];
		ent_rd_q  <= ent_mem[slot_idx];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_CLEAR;
			cmd_q        <= chmlp_pkg::CMD_LOOKUP;
			key_q        <= '0;
			handle_q     <= '0;
			length_q     <= '0;
			prod_q       <= '0;
			hash_q       <= '0;
			probe_q      <= '0;
			steps_q      <= '0;
			count_q      <= '0;
			height_q     <= '0;
			width_q      <= '0;
			res_found_q  <= 1'b0;
			res_handle_q <= '0;
			res_length_q <= '0;
			res_status_q <= 1'b0;
			out_valid_q  <= 1'b0;
			out_data_q   <= '0;
			out_user_q   <= '0;
		end else begin
			// In the done state the output register is reloaded below instead.
			if (out_valid_q && m_axis_tready && state_q != ST_DONE) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_CLEAR: begin
					probe_q <= probe_next;
					if (probe_q == SW'(SLOT_COUNT - 1)) begin
						state_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (s_axis_tvalid) begin
						cmd_q        <= in_cmd;
						key_q        <= {in_row, in_col};
						handle_q     <= s_axis_tdata[KEY_W+HW-1:KEY_W];
						length_q     <= s_axis_tdata[KEY_W+HW+LW-1:KEY_W+HW];
						res_found_q  <= 1'b0;
						res_handle_q <= '0;
						res_length_q <= '0;
						res_status_q <= 1'b0;
						if (in_cmd == chmlp_pkg::CMD_SET) begin
							if (row_next > height_q) begin
								height_q <= row_next;
							end
							if (col_next > width_q) begin
								width_q <= col_next;
							end
							state_q <= ST_HASH0;
						end else if (out_of_bounds) begin
							state_q <= ST_DONE;
						end else begin
							state_q <= ST_HASH0;
						end
					end
				end
				ST_HASH0: begin
					prod_q  <= mul_lo[63:32];
					state_q <= ST_HASH1;
				end
				ST_HASH1: begin
					// Top half of m ^ (m >> 29).
					hash_q  <= hash_hi ^ {29'd0, hash_hi[31:29]};
					state_q <= ST_HASH2;
				end
				ST_HASH2: begin
					probe_q <= home_prod[32 +: SW];
					steps_q <= '0;
					state_q <= ST_SLOT_RD;
				end
				ST_SLOT_RD: begin
					state_q <= ST_SLOT_CHK;
				end
				ST_SLOT_CHK: begin
					if (slot_vld) begin
						state_q <= ST_ENT_CHK;
					end else begin
						if (cmd_q == chmlp_pkg::CMD_SET) begin
							if (has_room) begin
								count_q <= count_q + 1'b1;
							end else begin
								res_status_q <= 1'b1;
							end
						end
						state_q <= ST_DONE;
					end
				end
				ST_ENT_CHK: begin
					if (key_hit) begin
						if (cmd_q == chmlp_pkg::CMD_LOOKUP) begin
							res_found_q  <= 1'b1;
							res_handle_q <= ent_rd_q[HW-1:0];
							res_length_q <= ent_rd_q[VAL_W-1:HW];
						end
						state_q <= ST_DONE;
					end else if (steps_q == SW'(SLOT_COUNT - 1)) begin
						// Every slot visited without an empty one: a set flags no room for a new cell.
						res_status_q <= cmd_q;
						state_q      <= ST_DONE;
					end else begin
						probe_q <= probe_next;
						steps_q <= steps_q + 1'b1;
						state_q <= ST_SLOT_RD;
					end
				end
				ST_DONE: begin
					if (!out_valid_q || m_axis_tready) begin
						out_valid_q <= 1'b1;
						out_data_q  <= {res_length_q, res_handle_q};
						out_user_q  <= {res_status_q, res_found_q};
						state_q     <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign s_axis_tready = (state_q == ST_IDLE);
	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = out_data_q;
	assign m_axis_tuser  = out_user_q;

endmodule
